[hw/rtl/mbps_pkg.sv]
// Shared types, constants and helpers for the masked byte pattern search block.
package mbps_pkg;

    localparam int MAX_PATTERN_BYTES = 32;
    localparam int PATTERN_REG_BYTES = 32;
    localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_LEN_W = 6;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_0_7   = 8'd0,
        REG_PATTERN_8_15  = 8'd1,
        REG_PATTERN_16_23 = 8'd2,
        REG_PATTERN_24_31 = 8'd3,
        REG_CARE_MASK     = 8'd4,
        REG_PATTERN_LEN   = 8'd5,
        REG_REGION_BASE   = 8'd6
    } cfg_reg_t;

    typedef logic [MAX_PATTERN_BYTES-1:0][7:0] window_t;

    typedef struct packed {
        logic [PATTERN_REG_BYTES-1:0][7:0] pattern;
        logic [31:0]                       care_mask;
        logic [LEN_W-1:0]                  length;
        logic [63:0]                       region_base;
    } cfg_t;

    // Clamp the programmed length to the range 1 .. MAX_PATTERN_BYTES.
    function automatic logic [LEN_W-1:0] effective_length(input logic [CFG_LEN_W-1:0] raw);
        logic [LEN_W-1:0] len;
        if (raw == '0) begin
            len = LEN_W'(1);
        end else if (32'(raw) > 32'(MAX_PATTERN_BYTES)) begin
            len = LEN_W'(MAX_PATTERN_BYTES);
        end else begin
            len = LEN_W'(raw);
        end
        return len;
    endfunction

endpackage

[hw/rtl/mbps_cfg_regs.sv]
// Configuration register file for the pattern search: pattern, care mask, length, base.
module mbps_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [63:0]                         cfg_data,
    output mbps_pkg::cfg_t                      cfg
);
    import mbps_pkg::*;

    logic [63:0]          pat0_reg, pat1_reg, pat2_reg, pat3_reg;
    logic [31:0]          care_reg;
    logic [CFG_LEN_W-1:0] len_reg;
    logic [63:0]          base_reg;
    logic                 wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat0_reg <= '0;
            pat1_reg <= '0;
            pat2_reg <= '0;
            pat3_reg <= '0;
            care_reg <= '0;
            len_reg  <= CFG_LEN_W'(1);
            base_reg <= '0;
        end else if (wr_en) begin
            case (cfg_index)
                REG_PATTERN_0_7:   pat0_reg <= cfg_data;
                REG_PATTERN_8_15:  pat1_reg <= cfg_data;
                REG_PATTERN_16_23: pat2_reg <= cfg_data;
                REG_PATTERN_24_31: pat3_reg <= cfg_data;
                REG_CARE_MASK:     care_reg <= cfg_data[31:0];
                REG_PATTERN_LEN:   len_reg  <= cfg_data[CFG_LEN_W-1:0];
                REG_REGION_BASE:   base_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.pattern     = {pat3_reg, pat2_reg, pat1_reg, pat0_reg};
        cfg.care_mask   = care_reg;
        cfg.length      = effective_length(len_reg);
        cfg.region_base = base_reg;
    end

endmodule

[hw/rtl/mbps_window_cmp.sv]
// Parallel masked compare of the byte window against the configured pattern.
module mbps_window_cmp (
    input  mbps_pkg::window_t window,
    input  mbps_pkg::cfg_t    cfg,
    output logic              match
);
    import mbps_pkg::*;

    logic [MAX_PATTERN_BYTES-1:0] miss;

    // Pattern byte k lines up with the byte that arrived length-1-k steps ago.
    always_comb begin
        for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            logic [LEN_W-1:0] pos;
            pos     = cfg.length - LEN_W'(1) - LEN_W'(k);
            miss[k] = (LEN_W'(k) < cfg.length) && cfg.care_mask[k] &&
                      (window[pos[IDX_W-1:0]] != cfg.pattern[k]);
        end
    end

    assign match = (miss == '0);

endmodule

[hw/rtl/masked_byte_pattern_search.sv]
// Top level of the masked byte pattern search: input register, scan state, result register.
//
//   channel   ports                                   direction
//   input     s_valid s_ready s_data_byte s_final_byte  in  (region bytes)
//   result    m_valid m_ready m_found m_match_address   out (one per region)
//   config    cfg_valid cfg_ready cfg_index cfg_data    in  (register writes)
//
// One byte is taken every cycle while the result register is empty or m_ready is high; a byte
// is held in the input register and its result is then loaded into the result register, where
// m_valid rises. The pace is set by the combinational window shift and 32-way masked compare.
// Reset clears the window, the byte count and the reported flag; config registers reset too.
// While m_ready is low the result register holds, the input register takes one more byte,
// and then s_ready drops until the result is taken.
module masked_byte_pattern_search (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_data_byte,
    input  logic                             s_final_byte,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_found,
    output logic [63:0]                      m_match_address,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]                      cfg_data
);
    import mbps_pkg::*;

    cfg_t        cfg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    window_t     window_reg;
    window_t     window_shift;
    window_t     window_next;
    logic [63:0] seen_reg;
    logic [63:0] seen_next;
    logic        reported_reg;
    logic        reported_next;
    logic        out_valid_reg;
    logic        out_found_reg;
    logic [63:0] out_addr_reg;
    logic        advance;
    logic        match;
    logic        seen_sat;
    logic        enough;
    logic        hit;
    logic        result_valid;
    logic [63:0] hit_addr;

    mbps_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_final_byte;
        end
    end

    always_comb begin
        window_shift = {window_reg[MAX_PATTERN_BYTES-2:0], in_byte_reg};
    end

    mbps_window_cmp u_cmp (
        .window (window_shift),
        .cfg    (cfg),
        .match  (match)
    );

    // The incremented count reaches the length exactly when the old count reaches length-1.
    assign seen_sat     = &seen_reg;
    assign enough       = seen_sat || (seen_reg >= 64'(cfg.length - LEN_W'(1)));
    assign hit          = !reported_reg && enough && (cfg.region_base != '0) && match;
    assign result_valid = hit || (in_last_reg && !reported_reg);
    assign hit_addr     = cfg.region_base + seen_reg + 64'(!seen_sat) - 64'(cfg.length);

    always_comb begin
        if (in_last_reg) begin
            window_next   = '0;
            seen_next     = '0;
            reported_next = 1'b0;
        end else begin
            window_next   = window_shift;
            seen_next     = seen_sat ? seen_reg : seen_reg + 64'd1;
            reported_next = reported_reg || hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg   <= '0;
            seen_reg     <= '0;
            reported_reg <= 1'b0;
        end else if (advance) begin
            window_reg   <= window_next;
            seen_reg     <= seen_next;
            reported_reg <= reported_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && result_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result_valid) begin
            out_found_reg <= hit;
            out_addr_reg  <= hit ? hit_addr : '0;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_found         = out_found_reg;
    assign m_match_address = out_addr_reg;

    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_match_address == '0)
        else $error("not-found result carries a nonzero address");

    a_rearm: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg |=> seen_reg == '0 && !reported_reg && window_reg == '0)
        else $error("scan state not cleared after the last byte of a region");

    a_final_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg && !reported_reg |=> m_valid)
        else $error("region ended without a result");

    a_input_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg)
            && $stable(in_last_reg))
        else $error("stalled request lost from the input register");

endmodule

[verif/tb_masked_byte_pattern_search.sv]
// Self-checking testbench for the masked byte pattern search block.
module tb_masked_byte_pattern_search;
    import mbps_pkg::*;

    localparam int unsigned QUIET_LIMIT = 3000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned PHASE_COUNT = 10;
    localparam int unsigned PHASE_BYTES = 160;
    localparam int unsigned HOLD_PHASE = 7;
    localparam logic [CFG_INDEX_W-1:0] UNMAPPED_REG = 8'd200;

    typedef struct packed {
        logic        found;
        logic [63:0] address;
    } region_outcome_t;

    typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

    // Tracks the scan state of the block and the outcomes it still owes.
    class region_scan_board;
        logic [63:0]     pattern_words [4];
        logic [31:0]     care_bits;
        logic [5:0]      length_raw;
        logic [63:0]     base_addr;
        window_t         recent_bytes;
        logic [63:0]     seen_count;
        bit              reported;
        region_outcome_t owed_outcomes [$];
        int unsigned     failures;

        function new();
            foreach (pattern_words[i]) pattern_words[i] = '0;
            care_bits = '0;
            length_raw = 6'd1;
            base_addr = '0;
            recent_bytes = '0;
            seen_count = '0;
            reported = 1'b0;
            failures = 0;
        endfunction

        function void apply_write(logic [CFG_INDEX_W-1:0] idx, logic [63:0] value);
            case (idx)
                REG_PATTERN_0_7:   pattern_words[0] = value;
                REG_PATTERN_8_15:  pattern_words[1] = value;
                REG_PATTERN_16_23: pattern_words[2] = value;
                REG_PATTERN_24_31: pattern_words[3] = value;
                REG_CARE_MASK:     care_bits = value[31:0];
                REG_PATTERN_LEN:   length_raw = value[5:0];
                REG_REGION_BASE:   base_addr = value;
                default: ;
            endcase
        endfunction

        function int unsigned active_length();
            if (length_raw == 0) return 1;
            if (length_raw > MAX_PATTERN_BYTES) return MAX_PATTERN_BYTES;
            return length_raw;
        endfunction

        function logic [7:0] pattern_byte(int unsigned k);
            return pattern_words[k / 8][(k % 8) * 8 +: 8];
        endfunction

        function void take_byte(logic [7:0] data, logic last);
            int unsigned len;
            int unsigned k;
            bit hit;
            len = active_length();
            recent_bytes = {recent_bytes[MAX_PATTERN_BYTES-2:0], data};
            if (seen_count != '1) seen_count++;
            if (!reported && seen_count >= len && base_addr != 0) begin
                hit = 1'b1;
                for (k = 0; k < len; k++) begin
                    if (care_bits[k] && recent_bytes[len-1-k] != pattern_byte(k)) hit = 1'b0;
                end
                if (hit) begin
                    owed_outcomes.push_back('{1'b1, base_addr + (seen_count - 64'(len))});
                    reported = 1'b1;
                end
            end
            if (last) begin
                if (!reported) owed_outcomes.push_back('{1'b0, 64'd0});
                seen_count = '0;
                reported = 1'b0;
                recent_bytes = '0;
            end
        endfunction

        function void check_outcome(logic found, logic [63:0] address);
            region_outcome_t want;
            if (owed_outcomes.size() == 0) begin
                $display("%0t: unexpected result, found %0b address %h", $time, found, address);
                failures++;
                return;
            end
            want = owed_outcomes.pop_front();
            if (found !== want.found) begin
                $display("%0t: found expected %0b actual %0b", $time, want.found, found);
                failures++;
            end
            if (address !== want.address) begin
                $display("%0t: match_address expected %h actual %h",
                         $time, want.address, address);
                failures++;
            end
        endfunction

        function void flag_leftovers();
            if (owed_outcomes.size() != 0) begin
                $display("%0t: %0d results never arrived, oldest expected found %0b address %h",
                         $time, owed_outcomes.size(), owed_outcomes[0].found,
                         owed_outcomes[0].address);
                failures++;
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_data_byte = '0;
    logic                   s_final_byte = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_found;
    logic [63:0]            m_match_address;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [63:0]            cfg_data = '0;

    region_scan_board board;
    logic [7:0]       region_bytes [$];
    int unsigned      burst_left = 0;
    int unsigned      quiet_cycles = 0;
    bit               hold_pending = 1'b0;
    int unsigned      hold_left = 0;
    rx_mode_t         rx_mode = RX_STEADY;
    int unsigned      mode_left = 0;
    int unsigned      stall_left = 0;

    masked_byte_pattern_search uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_final_byte    (s_final_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_found         (m_found),
        .m_match_address (m_match_address),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Result side: check every accepted result, then pick the next ready value.
    always @(posedge aclk) begin
        if (m_valid && m_ready) board.check_outcome(m_found, m_match_address);
        if (hold_pending) begin
            hold_left = HOLD_CYCLES;
            hold_pending = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
                stall_left = 0;
            end
            mode_left--;
            case (rx_mode)
                RX_STEADY: m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        m_ready <= 1'b0;
                    end else begin
                        m_ready <= 1'b1;
                        stall_left = $urandom_range(0, 1) ? $urandom_range(3, 25) : 0;
                    end
                end
            endcase
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Sends one byte in bursts of random length separated by random gaps.
    task automatic offer_byte(input logic [7:0] data, input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data_byte <= data;
        s_final_byte <= last;
        do @(posedge aclk); while (!s_ready);
        board.take_byte(data, last);
    endtask

    // Leaves cfg_valid high; the caller lowers it once its writes are done.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        board.apply_write(idx, value);
    endtask

    task automatic program_search(input logic [63:0] w0, input logic [63:0] w1,
                                  input logic [63:0] w2, input logic [63:0] w3,
                                  input logic [31:0] mask, input logic [5:0] len,
                                  input logic [63:0] base);
        write_reg(REG_PATTERN_0_7, w0);
        write_reg(REG_PATTERN_8_15, w1);
        write_reg(REG_PATTERN_16_23, w2);
        write_reg(REG_PATTERN_24_31, w3);
        write_reg(REG_CARE_MASK, 64'(mask));
        write_reg(REG_PATTERN_LEN, 64'(len));
        write_reg(REG_REGION_BASE, base);
        cfg_valid <= 1'b0;
    endtask

    // Stops the sender and waits until every owed result has been taken,
    // plus the pipeline depth so that bytes with no result have cleared too.
    task automatic wait_drained();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (board.owed_outcomes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Appends the first count bytes of a pattern occurrence; a cared byte at
    // spoil_at is corrupted so the occurrence fails to match.
    function automatic void append_occurrence(int unsigned count, int spoil_at);
        int unsigned k;
        logic [7:0] b;
        for (k = 0; k < count; k++) begin
            b = board.care_bits[k] ? board.pattern_byte(k) : 8'($urandom);
            if (int'(k) == spoil_at) b ^= 8'($urandom_range(1, 255));
            region_bytes.push_back(b);
        end
    endfunction

    task automatic send_region();
        int unsigned len;
        int unsigned kind;
        int          spoil_at;
        int unsigned i;
        len = board.active_length();
        kind = $urandom_range(0, 99);
        region_bytes.delete();
        if (kind < 65) begin
            repeat ($urandom_range(0, 8)) region_bytes.push_back(8'($urandom));
            append_occurrence(len, -1);
            if ($urandom_range(0, 3) == 0) append_occurrence(len, -1);
            if ($urandom_range(0, 2) != 0) begin
                repeat ($urandom_range(0, 6)) region_bytes.push_back(8'($urandom));
            end
        end else if (kind < 80) begin
            append_occurrence((len > 1) ? $urandom_range(1, len - 1) : 1, -1);
        end else if (kind < 90) begin
            spoil_at = $urandom_range(0, len - 1);
            if (!board.care_bits[spoil_at]) begin
                spoil_at = -1;
                for (i = 0; i < len; i++) begin
                    if (board.care_bits[i] && spoil_at < 0) spoil_at = i;
                end
            end
            repeat ($urandom_range(0, 4)) region_bytes.push_back(8'($urandom));
            append_occurrence(len, spoil_at);
        end else begin
            repeat ($urandom_range(1, 40)) region_bytes.push_back(8'($urandom));
        end
        for (i = 0; i < region_bytes.size(); i++) begin
            offer_byte(region_bytes[i], i == region_bytes.size() - 1);
        end
    endtask

    task automatic configure_phase(input int unsigned phase);
        case (phase)
            0: begin
                write_reg(UNMAPPED_REG, rand_word());
                program_search(rand_word(), rand_word(), rand_word(), rand_word(),
                               '1, 6'd1, rand_word());
            end
            1: program_search('1, '0, rand_word(), rand_word(), '1, 6'd32, '1);
            2: program_search(rand_word(), rand_word(), rand_word(), rand_word(),
                              $urandom, 6'd0, rand_word());
            3: program_search(rand_word(), rand_word(), rand_word(), rand_word(),
                              $urandom & $urandom, 6'd63, rand_word());
            4: program_search(rand_word(), rand_word(), rand_word(), rand_word(),
                              '0, 6'($urandom_range(1, 32)), rand_word());
            5: program_search(rand_word(), '0, '0, '0, '1, 6'($urandom_range(1, 8)), '0);
            6: program_search(rand_word(), rand_word(), rand_word(), rand_word(),
                              $urandom, 6'd33, rand_word());
            default: program_search(rand_word(), rand_word(), rand_word(), rand_word(),
                                    $urandom | $urandom, 6'($urandom_range(1, 12)),
                                    rand_word());
        endcase
    endtask

    initial begin
        int unsigned phase;
        int unsigned phase_start;
        int unsigned sent;
        board = new();
        aresetn <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings have a zero base, so a region can only end in not-found.
        offer_byte(8'h00, 1'b0);
        offer_byte(8'hFF, 1'b1);
        wait_drained();

        // Byte 2 is a wildcard, care bits above the length are set, and the
        // base sits at the top of the address space so the address sum in the block wraps.
        program_search(64'h0000_0000_EFBE_ADDE, '1, '0, '1, 32'hFFFF_FFFB, 6'd4,
                       64'hFFFF_FFFF_FFFF_FFFE);
        offer_byte(8'h11, 1'b0);
        offer_byte(8'hDE, 1'b0);
        offer_byte(8'hAD, 1'b0);
        offer_byte(8'h00, 1'b0);
        offer_byte(8'hEF, 1'b0);
        offer_byte(8'h22, 1'b1);
        // Region shorter than the pattern.
        offer_byte(8'hDE, 1'b0);
        offer_byte(8'hAD, 1'b0);
        offer_byte(8'hBE, 1'b1);
        // Match completed by the final byte.
        offer_byte(8'hDE, 1'b0);
        offer_byte(8'hAD, 1'b0);
        offer_byte(8'h77, 1'b0);
        offer_byte(8'hEF, 1'b1);
        // Shorten the pattern in the middle of a region.
        offer_byte(8'h55, 1'b0);
        offer_byte(8'hDE, 1'b0);
        wait_drained();
        write_reg(REG_PATTERN_LEN, 64'd2);
        cfg_valid <= 1'b0;
        offer_byte(8'hAD, 1'b0);
        offer_byte(8'hFF, 1'b1);
        wait_drained();
        // Zero length with no care bits: every byte position is a wildcard.
        program_search(rand_word(), rand_word(), rand_word(), rand_word(), '0, 6'd0,
                       rand_word());
        offer_byte(8'h00, 1'b1);
        wait_drained();
        write_reg(REG_PATTERN_LEN, 64'd63);
        cfg_valid <= 1'b0;
        offer_byte(8'h01, 1'b0);
        offer_byte(8'h80, 1'b0);
        offer_byte(8'h7F, 1'b1);
        wait_drained();

        sent = 0;
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            configure_phase(phase);
            phase_start = sent;
            if (phase == HOLD_PHASE) begin
                // Hold off the result side while one-byte regions keep coming,
                // so the block fills up and stalls its input.
                hold_pending = 1'b1;
                repeat (40) offer_byte(8'($urandom), 1'b1);
                sent += 40;
            end
            while (sent - phase_start < PHASE_BYTES) begin
                send_region();
                sent += region_bytes.size();
            end
            wait_drained();
        end

        board.flag_leftovers();
        if (board.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/mbps_pkg.sv
hw/rtl/mbps_cfg_regs.sv
hw/rtl/mbps_window_cmp.sv
hw/rtl/masked_byte_pattern_search.sv
verif/tb_masked_byte_pattern_search.sv
